FILE: sv/qpld_pkg.sv
package qpld_pkg;

    // Characters that steer the decoding.
    localparam logic [7:0] CH_EQ = 8'h3D;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    // Most results that one input byte can cause.
    localparam int unsigned MAX_RESULTS = 3;

    // What is held back after an '='.
    typedef enum logic [1:0] {
        PEND_NONE    = 2'd0,
        PEND_EQ      = 2'd1,
        PEND_EQ_BYTE = 2'd2
    } pend_t;

    // One result request as it waits in the output queue.
    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       last;
        logic       soft_brk;
    } qpld_result_t;

endpackage

FILE: sv/quoted_printable_line_decoder.sv
// Quoted-printable line decoder.
//
// The slave channel (s_tvalid, s_tready, s_tdata, s_tlast) takes one raw byte
// of an encoded text line per request; s_tlast marks the last byte of a line.
// The master channel (m_tvalid, m_tready, m_tdata, m_tuser, m_tlast) returns
// the decoded stream. Each input byte causes zero to three result requests.
// Escapes of the form '=' plus two hex digits become one byte, soft breaks
// are dropped, and the final result of a line carries m_tlast together with
// a flag telling whether the line ended in a soft break.
//
// Results of an accepted byte are registered in the result queue and reach
// the master side from there. The slave side takes one byte per cycle while
// each byte causes at most one result and m_tready is high; the master side
// drains one result per cycle while m_tready is high.
// The decode runs as one short combinational pass from the held lookahead
// state into a four-entry result queue; s_tready is high whenever the queue
// holds at most one result, so it depends on registers only.
//
// Reset empties the queue and drops any held lookahead. When the receiver
// stalls, results wait in the queue and s_tready falls once it holds two or more.
module quoted_printable_line_decoder
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // line_last

    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [1:0] m_tuser,   // [0] out_valid, [1] soft_break
    output logic       m_tlast    // line_end
);

    localparam int unsigned QDEPTH = 4;

    // Lookahead state: what follows an '=' that has not been settled yet.
    qpld_pkg::pend_t pend_reg;
    qpld_pkg::pend_t pend_next;
    logic [7:0]      held_reg;
    logic [7:0]      held_next;

    // Result queue: a small ring of registers with one read position.
    qpld_pkg::qpld_result_t queue_reg [QDEPTH];
    logic [1:0]             rd_ptr_reg;
    logic [1:0]             rd_ptr_next;
    logic [1:0]             wr_ptr_reg;
    logic [1:0]             wr_ptr_next;
    logic [2:0]             count_reg;
    logic [2:0]             count_next;

    // Results of the byte on the slave port.
    qpld_pkg::qpld_result_t res [qpld_pkg::MAX_RESULTS];
    logic [1:0]             res_n;

    logic in_take;
    logic out_take;

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
               (c >= 8'h61 && c <= 8'h66);
    endfunction

    // Letters of either case share their low nibble: 'A' and 'a' end in 1.
    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [3:0] v;
        if (c <= 8'h39)
        begin
            v = c[3:0];
        end
        else
        begin
            v = c[3:0] + 4'd9;
        end
        return v;
    endfunction

    function automatic qpld_pkg::qpld_result_t mk_res(input logic [7:0] b,
                                                      input logic valid,
                                                      input logic last,
                                                      input logic soft_brk);
        qpld_pkg::qpld_result_t r;
        r.data     = valid ? b : 8'h00;
        r.valid    = valid;
        r.last     = last;
        r.soft_brk = last & soft_brk;
        return r;
    endfunction

    assign s_tready = (count_reg <= 3'd1);
    assign in_take  = s_tvalid & s_tready;
    assign m_tvalid = (count_reg != 3'd0);
    assign out_take = m_tvalid & m_tready;

    // Decode one byte against the held lookahead.
    always_comb
    begin
        logic do_fresh;
        logic [7:0] b;
        logic last;

        b         = s_tdata;
        last      = s_tlast;
        do_fresh  = 1'b0;
        res_n     = 2'd0;
        pend_next = pend_reg;
        held_next = held_reg;
        for (int i = 0; i < qpld_pkg::MAX_RESULTS; i++)
        begin
            res[i] = '0;
        end

        case (pend_reg)
            qpld_pkg::PEND_EQ:
            begin
                if (b == qpld_pkg::CH_LF)
                begin
                    pend_next = qpld_pkg::PEND_NONE;
                    if (last)
                    begin
                        res[res_n] = mk_res(8'h00, 1'b0, 1'b1, 1'b1);
                        res_n      = res_n + 2'd1;
                    end
                end
                else if (is_hex(b) || b == qpld_pkg::CH_CR)
                begin
                    if (last)
                    begin
                        res[res_n] = mk_res(qpld_pkg::CH_EQ, 1'b1, 1'b0, 1'b0);
                        res_n      = res_n + 2'd1;
                        res[res_n] = mk_res(b, 1'b1, 1'b1, 1'b0);
                        res_n      = res_n + 2'd1;
                        pend_next  = qpld_pkg::PEND_NONE;
                    end
                    else
                    begin
                        held_next = b;
                        pend_next = qpld_pkg::PEND_EQ_BYTE;
                    end
                end
                else
                begin
                    res[res_n] = mk_res(qpld_pkg::CH_EQ, 1'b1, 1'b0, 1'b0);
                    res_n      = res_n + 2'd1;
                    do_fresh   = 1'b1;
                end
            end
            qpld_pkg::PEND_EQ_BYTE:
            begin
                if (is_hex(held_reg) && is_hex(b))
                begin
                    res[res_n] = mk_res({hex_val(held_reg), hex_val(b)}, 1'b1, last, 1'b0);
                    res_n      = res_n + 2'd1;
                    pend_next  = qpld_pkg::PEND_NONE;
                end
                else if (held_reg == qpld_pkg::CH_CR && b == qpld_pkg::CH_LF)
                begin
                    pend_next = qpld_pkg::PEND_NONE;
                    if (last)
                    begin
                        res[res_n] = mk_res(8'h00, 1'b0, 1'b1, 1'b1);
                        res_n      = res_n + 2'd1;
                    end
                end
                else
                begin
                    res[res_n] = mk_res(qpld_pkg::CH_EQ, 1'b1, 1'b0, 1'b0);
                    res_n      = res_n + 2'd1;
                    res[res_n] = mk_res(held_reg, 1'b1, 1'b0, 1'b0);
                    res_n      = res_n + 2'd1;
                    do_fresh   = 1'b1;
                end
            end
            default:
            begin
                do_fresh = 1'b1;
            end
        endcase

        // A byte examined with nothing held before it.
        if (do_fresh)
        begin
            if (b == qpld_pkg::CH_EQ)
            begin
                if (last)
                begin
                    res[res_n] = mk_res(8'h00, 1'b0, 1'b1, 1'b1);
                    res_n      = res_n + 2'd1;
                    pend_next  = qpld_pkg::PEND_NONE;
                end
                else
                begin
                    pend_next = qpld_pkg::PEND_EQ;
                end
            end
            else
            begin
                res[res_n] = mk_res(b, 1'b1, last, 1'b0);
                res_n      = res_n + 2'd1;
                pend_next  = qpld_pkg::PEND_NONE;
            end
        end
    end

    // Queue pointers and fill level.
    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        count_next  = count_reg;
        if (out_take)
        begin
            rd_ptr_next = rd_ptr_reg + 2'd1;
        end
        if (in_take)
        begin
            wr_ptr_next = wr_ptr_reg + res_n;
        end
        count_next = count_reg - {2'b00, out_take} + (in_take ? {1'b0, res_n} : 3'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg   <= qpld_pkg::PEND_NONE;
            held_reg   <= 8'h00;
            rd_ptr_reg <= 2'd0;
            wr_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end
        else
        begin
            if (in_take)
            begin
                pend_reg <= pend_next;
                held_reg <= held_next;
            end
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            for (int i = 0; i < qpld_pkg::MAX_RESULTS; i++)
            begin
                if (2'(i) < res_n)
                begin
                    queue_reg[wr_ptr_reg + 2'(i)] <= res[i];
                end
            end
        end
    end

    assign m_tdata    = queue_reg[rd_ptr_reg].data;
    assign m_tuser[0] = queue_reg[rd_ptr_reg].valid;
    assign m_tuser[1] = queue_reg[rd_ptr_reg].soft_brk;
    assign m_tlast    = queue_reg[rd_ptr_reg].last;

    // The queue never holds more than its depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 3'(QDEPTH))
        else $error("result queue overflow");

    // The fill level tracks the distance between write and read positions.
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 3'(QDEPTH)) || (wr_ptr_reg - rd_ptr_reg == count_reg[1:0]))
        else $error("queue pointers disagree with fill level");

    // A soft break is reported only on an empty result that ends the line.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tlast && !m_tuser[0] && m_tdata == 8'h00)
        else $error("malformed soft break result");

    // Held lookahead ends with the line: after a last byte nothing stays pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> pend_reg == qpld_pkg::PEND_NONE)
        else $error("lookahead left pending at end of line");

endmodule
